>>> hw/rtl/canhex_pkg.sv
// types, constants and control store of the frame-to-text encoder
package canhex_pkg;

    localparam int PC_W = 3;

    localparam logic [7:0] CHAR_EXT  = 8'h54;
    localparam logic [7:0] CHAR_STD  = 8'h74;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [3:0] LEN_MAX   = 4'd8;

    typedef enum logic [1:0] {
        SRC_TYPE,
        SRC_CHAN,
        SRC_HEX,
        SRC_CR
    } src_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_ID,
        LD_LEN,
        LD_BYTE_TS
    } ld_t;

    typedef struct packed {
        src_t            src;
        ld_t             ld;
        logic            br;
        logic [PC_W-1:0] tgt_more;
        logic [PC_W-1:0] tgt_done;
        logic            fin;
    } ctl_t;

    localparam logic [PC_W-1:0] PC_TYPE  = 3'd0;
    localparam logic [PC_W-1:0] PC_CHAN  = 3'd1;
    localparam logic [PC_W-1:0] PC_ID    = 3'd2;
    localparam logic [PC_W-1:0] PC_LEN   = 3'd3;
    localparam logic [PC_W-1:0] PC_BYTES = 3'd4;
    localparam logic [PC_W-1:0] PC_TS    = 3'd5;
    localparam logic [PC_W-1:0] PC_CR    = 3'd6;

    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t c;
        case (pc)
            PC_TYPE:  c = '{SRC_TYPE, LD_NONE,    1'b0, PC_CHAN,  PC_CHAN,  1'b0};
            PC_CHAN:  c = '{SRC_CHAN, LD_ID,      1'b0, PC_ID,    PC_ID,    1'b0};
            PC_ID:    c = '{SRC_HEX,  LD_LEN,     1'b0, PC_LEN,   PC_LEN,   1'b0};
            PC_LEN:   c = '{SRC_HEX,  LD_BYTE_TS, 1'b1, PC_BYTES, PC_TS,    1'b0};
            PC_BYTES: c = '{SRC_HEX,  LD_BYTE_TS, 1'b1, PC_BYTES, PC_TS,    1'b0};
            PC_TS:    c = '{SRC_HEX,  LD_NONE,    1'b0, PC_CR,    PC_CR,    1'b0};
            PC_CR:    c = '{SRC_CR,   LD_NONE,    1'b0, PC_TYPE,  PC_TYPE,  1'b1};
            default:  c = '{SRC_CR,   LD_NONE,    1'b0, PC_TYPE,  PC_TYPE,  1'b1};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'b0, nib};
        end
        else
        begin
            c = 8'h37 + {4'b0, nib};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/can_frame_to_ascii_hex_encoder_unit.sv
// can frame to slcan text line encoder, microcoded sequencer
//
//  channel | dir | tdata                                   | tlast
//  s_      | in  | frame fields, 120 bits                  | -
//  m_      | out | text character, 8 bits                  | closing cr
//
//  a frame of n characters (11 to 32) leaves one character a cycle from the
//  step counter, the first one through the busy flag and then the output register
//  the input is ready again in the same cycle that the cr sits in the output register
//  a stalled output holds the step counter; reset clears control only
module can_frame_to_ascii_hex_encoder_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // channel[1:0], extended[2], ident[31:3], length[35:32], payload[99:36],
    // timestamp[115:100], zero[119:116]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // text_char[7:0]
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);

    localparam int PW = canhex_pkg::PC_W;

    logic            busy_reg, busy_next;
    logic [PW-1:0]   pc_reg, pc_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [3:0]      bidx_reg, bidx_next;
    logic [31:0]     sh_reg, sh_next;
    logic            ext_reg;
    logic [1:0]      chan_reg;
    logic [28:0]     id_reg;
    logic [3:0]      len_reg;
    logic [63:0]     pay_reg;
    logic [15:0]     ts_reg;
    logic            ov_reg, ov_next;
    logic [7:0]      oc_reg, oc_next;
    logic            ol_reg, ol_next;

    canhex_pkg::ctl_t ctl;
    logic             accept, step, rep, more;
    logic [7:0]       ch, byte_sel;
    logic [3:0]       in_len;

    assign ctl      = canhex_pkg::ucode(pc_reg);
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign step     = busy_reg && (!ov_reg || m_tready);
    assign rep      = (ctl.src == canhex_pkg::SRC_HEX) && (cnt_reg != 3'd0);
    assign more     = bidx_reg != len_reg;
    assign byte_sel = 8'(pay_reg >> {bidx_reg[2:0], 3'b000});
    assign in_len   = (s_tdata[35:32] > canhex_pkg::LEN_MAX) ? canhex_pkg::LEN_MAX
                                                            : s_tdata[35:32];

    assign m_tvalid = ov_reg;
    assign m_tdata  = oc_reg;
    assign m_tlast  = ol_reg;

    always_comb
    begin
        case (ctl.src)
            canhex_pkg::SRC_TYPE: ch = ext_reg ? canhex_pkg::CHAR_EXT : canhex_pkg::CHAR_STD;
            canhex_pkg::SRC_CHAN: ch = canhex_pkg::CHAR_ZERO + {6'b0, chan_reg};
            canhex_pkg::SRC_HEX:  ch = canhex_pkg::hex_char(sh_reg[31:28]);
            canhex_pkg::SRC_CR:   ch = canhex_pkg::CHAR_CR;
            default:              ch = canhex_pkg::CHAR_CR;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        bidx_next = bidx_reg;
        sh_next   = sh_reg;
        ov_next   = ov_reg;
        oc_next   = oc_reg;
        ol_next   = ol_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = canhex_pkg::PC_TYPE;
            bidx_next = 4'd0;
        end
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        if (step)
        begin
            ov_next = 1'b1;
            oc_next = ch;
            ol_next = ctl.fin;
            if (rep)
            begin
                sh_next  = {sh_reg[27:0], 4'b0};
                cnt_next = cnt_reg - 3'd1;
            end
            else
            begin
                case (ctl.ld)
                    canhex_pkg::LD_ID:
                    begin
                        sh_next  = ext_reg ? {3'b0, id_reg} : {1'b0, id_reg[10:0], 20'b0};
                        cnt_next = ext_reg ? 3'd7 : 3'd2;
                    end
                    canhex_pkg::LD_LEN:
                    begin
                        sh_next  = {len_reg, 28'b0};
                        cnt_next = 3'd0;
                    end
                    canhex_pkg::LD_BYTE_TS:
                    begin
                        if (more)
                        begin
                            sh_next   = {byte_sel, 24'b0};
                            cnt_next  = 3'd1;
                            bidx_next = bidx_reg + 4'd1;
                        end
                        else
                        begin
                            sh_next  = {ts_reg, 16'b0};
                            cnt_next = 3'd3;
                        end
                    end
                    default:
                    begin
                        sh_next = sh_reg;
                    end
                endcase
                pc_next = (ctl.br && more) ? ctl.tgt_more : ctl.tgt_done;
                if (ctl.fin)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= canhex_pkg::PC_TYPE;
            cnt_reg  <= 3'd0;
            bidx_reg <= 4'd0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            bidx_reg <= bidx_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        oc_reg <= oc_next;
        ol_reg <= ol_next;
        if (accept)
        begin
            chan_reg <= s_tdata[1:0];
            ext_reg  <= s_tdata[2];
            id_reg   <= s_tdata[31:3];
            len_reg  <= in_len;
            pay_reg  <= s_tdata[99:36];
            ts_reg   <= s_tdata[115:100];
        end
    end

endmodule

>>> hw/rtl/canhex_checker.sv
// port-level checks of the frame-to-text encoder and their binding
module canhex_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a line");

    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second frame taken before the line ended");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no output item after a frame was taken");

    a_cr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == 8'h0D)
        else $error("last item is not a carriage return");

endmodule

bind can_frame_to_ascii_hex_encoder_unit canhex_checker u_canhex_checker (.*);
